/* sv/kto_pkg.sv */
// kto_pkg: shared types and codes for the keyed table with oldest-entry eviction.
// No dependencies; imported by kto_ctrl, kto_dpath and the top level.
package kto_pkg;

  // How the written slot was chosen
  typedef enum logic [1:0] {
    OUT_MATCH  = 2'd0,
    OUT_EMPTY  = 2'd1,
    OUT_OLDEST = 2'd2
  } outcome_t;

  localparam int KEY_W   = 64;
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture the incoming word, clear the search trackers
    logic scan_en;  // read one entry at scan_addr
    logic commit;   // write the chosen entry and register the result
  } kto_cmd_t;

endpackage

/* sv/kto_ctrl.sv */
// kto_ctrl: sequencer that walks the table once per word, then commits.
// Depends on kto_pkg.
module kto_ctrl import kto_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  output kto_cmd_t                   cmd,
  output logic [$clog2(ENTRIES)-1:0] scan_addr
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  state_t        state;
  logic [IW-1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          idx <= '0;
          if (start) state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (idx == LAST) begin
            state <= ST_DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DRAIN:  state <= ST_COMMIT;
        ST_COMMIT: state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  assign busy        = (state != ST_IDLE);
  assign cmd.load    = (state == ST_IDLE) && start;
  assign cmd.scan_en = (state == ST_SCAN);
  assign cmd.commit  = (state == ST_COMMIT);
  assign scan_addr   = idx;

endmodule

/* sv/kto_dpath.sv */
// kto_dpath: key/time memories, valid flags, search trackers and result registers.
// Depends on kto_pkg; driven by kto_ctrl commands.
module kto_dpath import kto_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  kto_cmd_t                   cmd,
  input  logic [$clog2(ENTRIES)-1:0] scan_addr,
  input  logic [KEY_W-1:0]           key,
  input  logic [TIME_W-1:0]          now,
  output logic                       done,
  output logic [SLOT_W-1:0]          slot,
  output logic [1:0]                 outcome,
  output logic [COUNT_W-1:0]         valid_count
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic [KEY_W-1:0]  key_mem  [ENTRIES];
  logic [TIME_W-1:0] time_mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [CW-1:0]      count;

  logic [KEY_W-1:0]  key_q;
  logic [TIME_W-1:0] now_q;

  // read stage
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [KEY_W-1:0]  key_rd;
  logic [TIME_W-1:0] time_rd;

  // trackers
  logic              found_match;
  logic [IW-1:0]     match_at;
  logic              found_empty;
  logic [IW-1:0]     empty_at;
  logic [IW-1:0]     oldest_at;
  logic [TIME_W-1:0] min_stamp;

  logic [IW-1:0] chosen;
  outcome_t      how;
  logic [CW-1:0] count_next;

  always_comb begin
    if (found_match) begin
      chosen = match_at;
      how    = OUT_MATCH;
    end else if (found_empty) begin
      chosen = empty_at;
      how    = OUT_EMPTY;
    end else begin
      chosen = oldest_at;
      how    = OUT_OLDEST;
    end
    count_next = (how == OUT_EMPTY) ? count + 1'b1 : count;
  end

  // memories: one read and one write port each
  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      key_rd  <= key_mem[scan_addr];
      time_rd <= time_mem[scan_addr];
    end
    if (cmd.commit) begin
      key_mem[chosen]  <= key_q;
      time_mem[chosen] <= now_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q <= key;
      now_q <= now;
    end
    rd_addr <= scan_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      count       <= '0;
      rd_en       <= 1'b0;
      found_match <= 1'b0;
      found_empty <= 1'b0;
      done        <= 1'b0;
    end else begin
      rd_en <= cmd.scan_en;
      done  <= cmd.commit;
      if (cmd.load) begin
        found_match <= 1'b0;
        found_empty <= 1'b0;
      end else if (rd_en) begin
        if (valid[rd_addr] && key_rd == key_q && !found_match) begin
          found_match <= 1'b1;
          match_at    <= rd_addr;
        end
        if (!valid[rd_addr] && !found_empty) begin
          found_empty <= 1'b1;
          empty_at    <= rd_addr;
        end
        // strict compare keeps the lowest index on a tie
        if (rd_addr == '0 || time_rd < min_stamp) begin
          oldest_at <= rd_addr;
          min_stamp <= time_rd;
        end
      end
      if (cmd.commit) begin
        valid[chosen] <= 1'b1;
        count         <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot        <= SLOT_W'(chosen);
      outcome     <= how;
      valid_count <= COUNT_W'(count_next);
    end
  end

endmodule

/* sv/keyed_table_insert_oldest_evict.sv */
// keyed_table_insert_oldest_evict: top level of the keyed table with oldest eviction.
// Depends on kto_pkg, kto_ctrl and kto_dpath.
//
// Usage:
//   Input channel: drive key and now and raise start. The word is taken at the
//   rising edge where start is high and busy is low; busy then stays high until
//   the word is finished.
//   Result channel: done is high for exactly one cycle with slot, outcome and
//   valid_count. The receiver cannot stall; the result is simply presented once.
//   outcome: 0 key already present, 1 empty slot filled, 2 oldest slot replaced.
// Timing:
//   The sequencer reads one table entry per cycle from the key and time
//   memories (single read port each); a word is a scan of every entry, a
//   drain step that finishes the last compare and a commit step. done appears
//   in the cycle where busy drops, so the next word is taken at the edge that
//   ends that cycle; a word is not accepted until the previous one is finished.
// Reset:
//   rst (synchronous) clears all valid flags and the fill count; the table is
//   usable the cycle after. Keys and times are not cleared; they are only
//   read behind a valid flag or once the table is full.
module keyed_table_insert_oldest_evict import kto_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [KEY_W-1:0]    key,
  input  logic [TIME_W-1:0]   now,
  output logic                done,
  output logic [SLOT_W-1:0]   slot,
  output logic [1:0]          outcome,
  output logic [COUNT_W-1:0]  valid_count
);

  kto_cmd_t                   cmd;
  logic [$clog2(ENTRIES)-1:0] scan_addr;

  kto_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .scan_addr (scan_addr)
  );

  kto_dpath #(.ENTRIES(ENTRIES)) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .scan_addr   (scan_addr),
    .key         (key),
    .now         (now),
    .done        (done),
    .slot        (slot),
    .outcome     (outcome),
    .valid_count (valid_count)
  );

  // an accepted word keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // the result is shown exactly when the block goes idle
  a_done_on_idle: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // after any write at least one entry is valid
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (valid_count != '0))
    else $error("result reports an empty table");

  // one result per word
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

endmodule

/* verif/tb_keyed_table_insert_oldest_evict.sv */
`timescale 1ns / 1ps
// tb_keyed_table_insert_oldest_evict: self-checking bench for the keyed table with oldest eviction.
// Depends on kto_pkg and keyed_table_insert_oldest_evict; a local table model predicts each result.
module tb_keyed_table_insert_oldest_evict;
  import kto_pkg::*;

  localparam int ENTRIES      = 16;
  localparam int RANDOM_WORDS = 1930;
  localparam int POOL_SIZE    = 24;   // more keys than slots: both hits and evictions
  localparam int IDLE_LIMIT   = 1000; // cycles with no accept and no done before giving up

  // One input word and one predicted result
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
  } table_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    outcome_t           outcome;
    logic [COUNT_W-1:0] count;
  } insert_result_t;

  logic               clk   = 1'b0;
  logic               rst   = 1'b1;
  logic               start = 1'b0;
  logic [KEY_W-1:0]   key   = '0;
  logic [TIME_W-1:0]  now   = '0;
  logic               busy;
  logic               done;
  logic [SLOT_W-1:0]  slot;
  logic [1:0]         outcome;
  logic [COUNT_W-1:0] valid_count;

  table_word_t    word_queue[$];        // words still to be sent
  insert_result_t expected_results[$];  // predictions awaiting done

  // Local copy of the table
  bit                model_valid[ENTRIES];
  logic [KEY_W-1:0]  model_key[ENTRIES];
  logic [TIME_W-1:0] model_stamp[ENTRIES];

  int mismatches   = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int outcome_hits[3] = '{0, 0, 0};
  int burst_left   = 0;
  int gap_left     = 0;
  int idle_cycles  = 0;

  always #4 clk = ~clk;

  keyed_table_insert_oldest_evict #(.ENTRIES(ENTRIES)) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .key        (key),
    .now        (now),
    .done       (done),
    .slot       (slot),
    .outcome    (outcome),
    .valid_count(valid_count)
  );

  // Slot choice: matching valid key first, then lowest free slot, then the
  // smallest stamp (plain unsigned compare, lowest index on a tie).
  function automatic insert_result_t predict_insert(logic [KEY_W-1:0] k, logic [TIME_W-1:0] t);
    insert_result_t r;
    int  i;
    int  pick;
    int  free_at;
    int  filled;
    bit  hit;
    bit  has_free;
    pick = 0;
    free_at = 0;
    filled = 0;
    hit = 1'b0;
    has_free = 1'b0;
    for (i = 0; i < ENTRIES; i++) begin
      if (!hit && model_valid[i] && model_key[i] == k) begin
        hit = 1'b1;
        pick = i;
      end
      if (!model_valid[i] && !has_free) begin
        has_free = 1'b1;
        free_at = i;
      end
    end
    if (hit) begin
      r.outcome = OUT_MATCH;
    end else if (has_free) begin
      pick = free_at;
      r.outcome = OUT_EMPTY;
    end else begin
      // table is full here, so every stamp has been written
      for (i = 1; i < ENTRIES; i++)
        if (model_stamp[i] < model_stamp[pick]) pick = i;
      r.outcome = OUT_OLDEST;
    end
    model_valid[pick] = 1'b1;
    model_key[pick]   = k;
    model_stamp[pick] = t;
    for (i = 0; i < ENTRIES; i++)
      if (model_valid[i]) filled++;
    r.slot  = pick[SLOT_W-1:0];
    r.count = filled[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  // Driver: bursts of back-to-back words separated by random gaps. start stays
  // high across a burst, so it is never lowered and raised in the same step.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (start && !busy) begin
      // word taken at this edge
      expected_results.push_back(predict_insert(key, now));
      words_sent++;
      void'(word_queue.pop_front());
      if (burst_left > 0 && word_queue.size() > 0) begin
        key <= word_queue[0].key;
        now <= word_queue[0].now;
        burst_left <= burst_left - 1;
      end else begin
        start <= 1'b0;
        gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 25);
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (word_queue.size() > 0) begin
        start <= 1'b1;
        key <= word_queue[0].key;
        now <= word_queue[0].now;
        // now and then a long run with no idling at all
        burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(0, 6);
      end
    end
  end

  // Monitor: every done word is checked against the oldest prediction
  always @(posedge clk) begin
    insert_result_t exp_r;
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result slot=%0d outcome=%0d count=%0d",
                                  slot, outcome, valid_count));
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.outcome <= OUT_OLDEST) outcome_hits[exp_r.outcome]++;
        if (slot !== exp_r.slot)
          report_mismatch($sformatf("result %0d slot %0d, expected %0d",
                                    results_seen, slot, exp_r.slot));
        if (outcome !== exp_r.outcome)
          report_mismatch($sformatf("result %0d outcome %0d, expected %0d",
                                    results_seen, outcome, exp_r.outcome));
        if (valid_count !== exp_r.count)
          report_mismatch($sformatf("result %0d valid_count %0d, expected %0d",
                                    results_seen, valid_count, exp_r.count));
      end
    end
  end

  // Watchdog: ends the run after too long with neither an accept nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    table_word_t       w;
    logic [KEY_W-1:0]  key_pool[POOL_SIZE];
    logic [TIME_W-1:0] clock_now;
    int                n;
    int                sel;

    // Directed: empty fill, match with free slots above it, extreme keys and
    // stamps, eviction of the smallest stamp, ties on the oldest stamp.
    word_queue.push_back('{key: '0, now: '0});             // fills slot 0
    word_queue.push_back('{key: '1, now: '1});             // fills slot 1
    word_queue.push_back('{key: '0, now: 32'd5});          // match, free slots remain
    for (n = 0; n < ENTRIES - 2; n++)                      // fill the rest, equal stamps
      word_queue.push_back('{key: 64'h8000_0000_0000_0000 >> n, now: 32'd100});
    word_queue.push_back('{key: 64'h0123_4567_89AB_CDEF, now: 32'd7});   // evicts slot 0
    word_queue.push_back('{key: 64'hFEDC_BA98_7654_3210, now: 32'd100}); // slot 0 again
    word_queue.push_back('{key: 64'h5A5A_5A5A_A5A5_A5A5, now: 32'd200}); // tie at 100
    word_queue.push_back('{key: '1, now: '0});             // match, stamp drops to zero
    word_queue.push_back('{key: 64'hA5A5_A5A5_5A5A_5A5A, now: '1});      // evicts slot 1

    // Random: mostly keys from a small pool so hits and evictions mix; stamps
    // mostly a slowly rising clock (repeats make ties), some wild or extreme.
    for (n = 0; n < POOL_SIZE; n++)
      key_pool[n] = {$urandom, $urandom};
    clock_now = $urandom_range(300, 1000);
    for (n = 0; n < RANDOM_WORDS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 60)
        w.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (sel < 65)
        w.key = $urandom_range(0, 1) ? '0 : '1;
      else
        w.key = {$urandom, $urandom};
      if ($urandom_range(0, 15) == 0)
        key_pool[$urandom_range(0, POOL_SIZE - 1)] = {$urandom, $urandom};
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        clock_now = clock_now + $urandom_range(0, 3);
        w.now = clock_now;
      end else if (sel < 80) begin
        w.now = $urandom;
      end else if (sel < 90) begin
        w.now = $urandom_range(0, 2);
      end else begin
        w.now = '1 - $urandom_range(0, 1);
      end
      word_queue.push_back(w);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Sample at the falling edge, clear of the driver's updates
    do @(negedge clk);
    while (word_queue.size() > 0 || expected_results.size() > 0);
    repeat (ENTRIES + 8) @(posedge clk);

    $display("sent %0d words, checked %0d results", words_sent, results_seen);
    $display("outcomes: %0d key hits, %0d free-slot fills, %0d oldest evictions",
             outcome_hits[0], outcome_hits[1], outcome_hits[2]);
    if (expected_results.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
